// ----- rtl/swmm_pkg.sv -----
// Shared types and constants for the sliding window minimum/maximum block.
package swmm_pkg;

	localparam int WINDOW_MAX_DEF = 64;
	localparam int SAMPLE_W       = 32;
	localparam int CFG_W          = 7;

	typedef logic signed [SAMPLE_W-1:0] smp_t;

	localparam smp_t SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam smp_t SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	// Running extremes that travel along the cell chain during a scan.
	typedef struct packed {
		logic vld;
		smp_t lo;
		smp_t hi;
	} tok_t;

endpackage

// ----- rtl/sliding_window_min_max_top.sv -----
// Top level of the sliding window minimum/maximum block.
//
// Input beats carry one signed 32-bit sample in s_axis_tdata and the
// first_sample flag in s_axis_tuser. A set flag starts a new sequence with
// that sample. Once the sequence holds at least window_len samples, each
// sample yields one output beat with the minimum and maximum of the most
// recent window_len samples. Earlier samples of a sequence give no beat. The
// window length register is written via cfg_we/cfg_wdata, by the user only while
// the block is idle (not enforced by the block); zero acts as one and values
// above WINDOW_MAX as WINDOW_MAX.
// Samples live in a chain of cells that shifts by one on every accepted beat.
// A scan token then walks the chain one cell per cycle unless the chain is held,
// folding in one sample at each; a beat that produces a result is folded over
// window_len cells into the output register, and only then is the next beat taken.
// A beat that produces no result is followed by the next one in the next cycle.
// The output register lets a new beat be accepted while a result waits. When
// the receiver stalls with a finished scan behind the held result, the token
// stays in its cell and s_axis_tready stays low until the result moves out.
// Reset empties the sequence, sets the window length to one and drops any
// scan or pending result; stored samples are not cleared and need not be.
module sliding_window_min_max_top import swmm_pkg::*; #(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // [31:0] sample
	input  logic [0:0]            s_axis_tuser,   // [0] first_sample
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [2*SAMPLE_W-1:0] m_axis_tdata,   // [31:0] window_min, [63:32] window_max
	input  logic                  cfg_we,
	input  logic [CFG_W-1:0]      cfg_wdata       // [6:0] window_len
);

	localparam int CNT_W = $clog2(WINDOW_MAX + 1);
	localparam int LEN_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	logic [CFG_W-1:0] window_len_q;
	logic [CNT_W-1:0] fill_q;
	logic             busy_q;
	logic             launch_q;
	logic             out_vld_q;
	smp_t             out_lo_q;
	smp_t             out_hi_q;

	logic [LEN_W-1:0] wl_ext;
	logic [CNT_W-1:0] len_eff;
	logic [CNT_W-1:0] fill_next;
	logic             has_result;
	logic             accept;
	logic             adv;
	logic             capture;
	logic             any_done;
	smp_t             sel_lo;
	smp_t             sel_hi;

	smp_t             smp_a  [WINDOW_MAX+1];
	tok_t             tok_a  [WINDOW_MAX+1];
	logic [CNT_W-1:0] rem_a  [WINDOW_MAX+1];
	logic             done_a [WINDOW_MAX];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= CFG_W'(1);
		end else if (cfg_we) begin
			window_len_q <= cfg_wdata;
		end
	end

	// Clamp the programmed length into the range the chain can cover.
	always_comb begin
		wl_ext = LEN_W'(window_len_q);
		if (wl_ext == '0) begin
			len_eff = CNT_W'(1);
		end else if (wl_ext > LEN_W'(WINDOW_MAX)) begin
			len_eff = CNT_W'(WINDOW_MAX);
		end else begin
			len_eff = CNT_W'(wl_ext);
		end
	end

	always_comb begin
		if (s_axis_tuser[0]) begin
			fill_next = CNT_W'(1);
		end else if (fill_q == CNT_W'(WINDOW_MAX)) begin
			fill_next = fill_q;
		end else begin
			fill_next = fill_q + CNT_W'(1);
		end
	end

	assign has_result    = (fill_next >= len_eff);
	assign s_axis_tready = !busy_q;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// The chain holds only while a finished scan cannot move into the output register.
	assign capture = any_done && (!out_vld_q || m_axis_tready);
	assign adv     = !(any_done && out_vld_q && !m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			busy_q   <= 1'b0;
			launch_q <= 1'b0;
		end else begin
			if (accept) begin
				fill_q   <= fill_next;
				busy_q   <= has_result;
				launch_q <= has_result;
			end else begin
				if (capture) begin
					busy_q <= 1'b0;
				end
				if (adv) begin
					launch_q <= 1'b0;
				end
			end
		end
	end

	// Head of the chain: the new sample and a fresh token sized to the window.
	assign smp_a[0] = smp_t'(s_axis_tdata);
	assign tok_a[0] = '{vld: launch_q, lo: SMP_MAX, hi: SMP_MIN};
	assign rem_a[0] = len_eff;

	for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
		swmm_cell #(
			.CNT_W (CNT_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (accept),
			.smp_in   (smp_a[g]),
			.smp_out  (smp_a[g+1]),
			.adv      (adv),
			.tok_in   (tok_a[g]),
			.rem_in   (rem_a[g]),
			.tok_out  (tok_a[g+1]),
			.rem_out  (rem_a[g+1]),
			.done     (done_a[g])
		);
	end

	// At most one cell holds a finished token, so an OR of the gated values selects it.
	always_comb begin
		any_done = 1'b0;
		sel_lo   = '0;
		sel_hi   = '0;
		for (int i = 0; i < WINDOW_MAX; i++) begin
			if (done_a[i]) begin
				any_done = 1'b1;
				sel_lo   = sel_lo | tok_a[i+1].lo;
				sel_hi   = sel_hi | tok_a[i+1].hi;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (capture) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			out_lo_q <= sel_lo;
			out_hi_q <= sel_hi;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {out_hi_q, out_lo_q};

endmodule

// ----- rtl/swmm_cell.sv -----
// One cell of the window chain: a stored sample and a stage of the extreme scan.
module swmm_cell import swmm_pkg::*; #(
	parameter int CNT_W = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift_en,
	input  smp_t             smp_in,
	output smp_t             smp_out,
	input  logic             adv,
	input  tok_t             tok_in,
	input  logic [CNT_W-1:0] rem_in,
	output tok_t             tok_out,
	output logic [CNT_W-1:0] rem_out,
	output logic             done
);

	smp_t             smp_q;
	logic             vld_q;
	smp_t             lo_q;
	smp_t             hi_q;
	logic [CNT_W-1:0] rem_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			smp_q <= smp_in;
		end
	end

	// A token with samples left to visit folds in this cell's sample and moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= tok_in.vld && (rem_in != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lo_q  <= (smp_q < tok_in.lo) ? smp_q : tok_in.lo;
			hi_q  <= (smp_q > tok_in.hi) ? smp_q : tok_in.hi;
			rem_q <= rem_in - CNT_W'(1);
		end
	end

	assign smp_out = smp_q;
	assign tok_out = '{vld: vld_q, lo: lo_q, hi: hi_q};
	assign rem_out = rem_q;
	assign done    = vld_q && (rem_q == '0);

endmodule

// ----- rtl/swmm_checker.sv -----
// Port-level checks for the sliding window minimum/maximum block, bound to the top level.
module swmm_checker import swmm_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [2*SAMPLE_W-1:0] m_axis_tdata
);

	// A result held for a stalled receiver keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed while stalled");

	// The window minimum never exceeds the window maximum.
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata[SAMPLE_W-1:0]) <=
			$signed(m_axis_tdata[2*SAMPLE_W-1:SAMPLE_W])))
		else $error("window minimum above window maximum");

	// A new result only ever comes out of a scan, during which no sample is taken.
	a_result_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result appeared without a scan");

	// Once the input side opens after a scan, that scan's result is valid on the output.
	a_ready_after_capture: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_axis_tready) |-> m_axis_tvalid)
		else $error("input reopened without a delivered result");

endmodule

bind sliding_window_min_max_top swmm_checker u_swmm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
